// ===== rtl/sjf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sjf_pkg - shared types and constants of the SJF schedule calculator
// Field widths, store word layout, sequencer states and divider status.
// ---------------------------------------------------------------------------
package sjf_pkg;

  // field widths
  localparam int BURST_W  = 16;
  localparam int JOB_ID_W = 7;
  localparam int WAIT_W   = 22;
  localparam int AVG_W    = 30;
  localparam int FRAC_W   = 8;

  // store word: {job id, burst}
  localparam int WORD_W = JOB_ID_W + BURST_W;

  // stream data widths, padded to whole bytes
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 128;

  // sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_EMIT_RD,
    ST_EMIT_DATA,
    ST_DIVW_GO,
    ST_DIVW_RUN,
    ST_DIVT_GO,
    ST_DIVT_RUN,
    ST_LOAD_OUT,
    ST_OUT
  } state_e;

  // divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/sjf_schedule_calculator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sjf_schedule_calculator - non-preemptive shortest-job-first scheduler
// Collects a set of burst times, sorts them and streams out the schedule
// with waiting, turnaround and average times.
// ---------------------------------------------------------------------------
// Jobs come in one word per cycle while the block is loading; the word with
// tlast closes the set and starts scheduling, and tready stays low until the
// last result of the schedule has been taken. The block sorts the stored jobs
// by selection sort (one store read per cycle through a single read port, a
// closing step after each scan, two writes per swap), then reads, computes,
// registers and offers each result in turn, waiting out any output stall, and
// runs two divisions of a 22 + clog2(MAX_JOBS) + 8 bit dividend, one bit per
// cycle through a shared restoring divider, each after a start state and
// ending on a done pulse, before the final result. Jobs beyond MAX_JOBS are
// dropped and flagged on tuser of every result of that set.
module sjf_schedule_calculator #(
  parameter int MAX_JOBS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // burst_time[15:0]
  input  wire logic [sjf_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input  wire logic                            s_axis_tlast,  // last_job
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // job_id[6:0], job_burst[22:7], waiting_time[44:23],
  // turnaround_time[66:45], avg_waiting_q8[96:67], avg_turnaround_q8[126:97]
  output logic      [sjf_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  output logic                                 m_axis_tuser,  // overflow
  output logic                                 m_axis_tlast,  // end_of_schedule
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready
);

  localparam int BurstW = sjf_pkg::BURST_W;
  localparam int IdW    = sjf_pkg::JOB_ID_W;
  localparam int WaitW  = sjf_pkg::WAIT_W;
  localparam int AvgW   = sjf_pkg::AVG_W;
  localparam int FracW  = sjf_pkg::FRAC_W;
  localparam int WordW  = sjf_pkg::WORD_W;
  localparam int CntW   = $clog2(MAX_JOBS + 1);
  localparam int IdxW   = $clog2(MAX_JOBS);
  localparam int SumW   = WaitW + $clog2(MAX_JOBS);
  localparam int DvdW   = SumW + FracW;

  sjf_pkg::state_e state_q, state_d;

  // control
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            dropped_q, dropped_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] j_q, j_d;
  logic            pend_q, pend_d;
  logic            first_q, first_d;
  logic            last_q, last_d;
  logic            out_valid_q, out_valid_d;

  // datapath
  logic [IdxW-1:0]  tag_q, tag_d;
  logic [WordW-1:0] min_word_q, min_word_d;
  logic [IdxW-1:0]  min_idx_q, min_idx_d;
  logic [WordW-1:0] word_i_q, word_i_d;
  logic [WaitW-1:0] wait_q, wait_d;
  logic [WaitW-1:0] turn_q, turn_d;
  logic [SumW-1:0]  wsum_q, wsum_d;
  logic [SumW-1:0]  tsum_q, tsum_d;
  logic [WordW-1:0] cur_word_q, cur_word_d;
  logic [AvgW-1:0]  avgw_q, avgw_d;
  logic [AvgW-1:0]  avgt_q, avgt_d;

  // output register
  logic [IdW-1:0]    o_id_q, o_id_d;
  logic [BurstW-1:0] o_burst_q, o_burst_d;
  logic [WaitW-1:0]  o_wait_q, o_wait_d;
  logic [WaitW-1:0]  o_turn_q, o_turn_d;
  logic [AvgW-1:0]   o_avgw_q, o_avgw_d;
  logic [AvgW-1:0]   o_avgt_q, o_avgt_d;
  logic              o_ovf_q, o_ovf_d;
  logic              o_eos_q, o_eos_d;

  // store and divider ports
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [WordW-1:0] ram_wdata;
  logic             ram_re;
  logic [IdxW-1:0]  ram_raddr;
  logic [WordW-1:0] ram_rdata;
  logic             div_start;
  logic [DvdW-1:0]  div_dvd;
  logic [DvdW-1:0]  div_quo;
  sjf_pkg::div_stat_t div_stat;

  // helpers
  logic             issue;
  logic [CntW-1:0]  i_inc;
  logic [WaitW-1:0] turn_sum;

  // job store: {id, burst} per entry
  sjf_ram #(
    .Width (WordW),
    .Depth (MAX_JOBS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // shared divider for both averages
  sjf_div #(
    .DvdW (DvdW),
    .DivW (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (cnt_q),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  assign i_inc    = i_q + CntW'(1);
  assign issue    = (j_q < cnt_q);
  assign turn_sum = wait_q + WaitW'(ram_rdata[BurstW-1:0]);

  // sequencer: next state and datapath
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dropped_d   = dropped_q;
    i_d         = i_q;
    j_d         = j_q;
    pend_d      = pend_q;
    first_d     = first_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    tag_d       = tag_q;
    min_word_d  = min_word_q;
    min_idx_d   = min_idx_q;
    word_i_d    = word_i_q;
    wait_d      = wait_q;
    turn_d      = turn_q;
    wsum_d      = wsum_q;
    tsum_d      = tsum_q;
    cur_word_d  = cur_word_q;
    avgw_d      = avgw_q;
    avgt_d      = avgt_q;
    o_id_d      = o_id_q;
    o_burst_d   = o_burst_q;
    o_wait_d    = o_wait_q;
    o_turn_d    = o_turn_q;
    o_avgw_d    = o_avgw_q;
    o_avgt_d    = o_avgt_q;
    o_ovf_d     = o_ovf_q;
    o_eos_d     = o_eos_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    div_start   = 1'b0;
    div_dvd     = '0;

    case (state_q)
      // take jobs until tlast
      sjf_pkg::ST_LOAD: begin
        if (s_axis_tvalid) begin
          if (cnt_q < CntW'(MAX_JOBS)) begin
            ram_we    = 1'b1;
            ram_waddr = cnt_q[IdxW-1:0];
            ram_wdata = {IdW'(cnt_q) + IdW'(1), s_axis_tdata[BurstW-1:0]};
            cnt_d     = cnt_q + CntW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (s_axis_tlast) begin
            state_d = sjf_pkg::ST_SCAN;
            i_d     = '0;
            j_d     = '0;
            first_d = 1'b1;
            pend_d  = 1'b0;
          end
        end
      end

      // minimum search over entries i..n-1, one read per cycle
      sjf_pkg::ST_SCAN: begin
        ram_re    = issue;
        ram_raddr = j_q[IdxW-1:0];
        if (issue) begin
          j_d = j_q + CntW'(1);
        end
        pend_d = issue;
        tag_d  = j_q[IdxW-1:0];
        if (pend_q) begin
          if (first_q) begin
            min_word_d = ram_rdata;
            min_idx_d  = tag_q;
            word_i_d   = ram_rdata;
            first_d    = 1'b0;
          end else if (ram_rdata[BurstW-1:0] < min_word_q[BurstW-1:0]) begin
            min_word_d = ram_rdata;
            min_idx_d  = tag_q;
          end
        end
        if (!issue && !pend_q) begin
          state_d = sjf_pkg::ST_SWAP_A;
        end
      end

      // swap entry i with the minimum
      sjf_pkg::ST_SWAP_A: begin
        ram_we    = 1'b1;
        ram_waddr = min_idx_q;
        ram_wdata = word_i_q;
        state_d   = sjf_pkg::ST_SWAP_B;
      end

      sjf_pkg::ST_SWAP_B: begin
        ram_we    = 1'b1;
        ram_waddr = i_q[IdxW-1:0];
        ram_wdata = min_word_q;
        if (i_inc == cnt_q) begin
          state_d = sjf_pkg::ST_EMIT_RD;
          i_d     = '0;
          wait_d  = '0;
          wsum_d  = '0;
          tsum_d  = '0;
        end else begin
          state_d = sjf_pkg::ST_SCAN;
          i_d     = i_inc;
          j_d     = i_inc;
          first_d = 1'b1;
        end
      end

      // fetch the next job in schedule order
      sjf_pkg::ST_EMIT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = i_q[IdxW-1:0];
        state_d   = sjf_pkg::ST_EMIT_DATA;
      end

      // times and running sums
      sjf_pkg::ST_EMIT_DATA: begin
        cur_word_d = ram_rdata;
        turn_d     = turn_sum;
        wsum_d     = wsum_q + SumW'(wait_q);
        tsum_d     = tsum_q + SumW'(turn_sum);
        last_d     = (i_inc == cnt_q);
        state_d    = (i_inc == cnt_q) ? sjf_pkg::ST_DIVW_GO : sjf_pkg::ST_LOAD_OUT;
      end

      // averages, one division after the other
      sjf_pkg::ST_DIVW_GO: begin
        div_start = 1'b1;
        div_dvd   = {wsum_q, {FracW{1'b0}}};
        state_d   = sjf_pkg::ST_DIVW_RUN;
      end

      sjf_pkg::ST_DIVW_RUN: begin
        if (div_stat.done) begin
          avgw_d  = div_quo[AvgW-1:0];
          state_d = sjf_pkg::ST_DIVT_GO;
        end
      end

      sjf_pkg::ST_DIVT_GO: begin
        div_start = 1'b1;
        div_dvd   = {tsum_q, {FracW{1'b0}}};
        state_d   = sjf_pkg::ST_DIVT_RUN;
      end

      sjf_pkg::ST_DIVT_RUN: begin
        if (div_stat.done) begin
          avgt_d  = div_quo[AvgW-1:0];
          state_d = sjf_pkg::ST_LOAD_OUT;
        end
      end

      // fill the output register
      sjf_pkg::ST_LOAD_OUT: begin
        o_id_d      = cur_word_q[WordW-1:BurstW];
        o_burst_d   = cur_word_q[BurstW-1:0];
        o_wait_d    = wait_q;
        o_turn_d    = turn_q;
        o_avgw_d    = last_q ? avgw_q : '0;
        o_avgt_d    = last_q ? avgt_q : '0;
        o_ovf_d     = dropped_q;
        o_eos_d     = last_q;
        out_valid_d = 1'b1;
        state_d     = sjf_pkg::ST_OUT;
      end

      // hold the word until taken
      sjf_pkg::ST_OUT: begin
        if (m_axis_tready) begin
          out_valid_d = 1'b0;
          wait_d      = turn_q;
          if (last_q) begin
            cnt_d     = '0;
            dropped_d = 1'b0;
            state_d   = sjf_pkg::ST_LOAD;
          end else begin
            i_d     = i_inc;
            state_d = sjf_pkg::ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_d = sjf_pkg::ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sjf_pkg::ST_LOAD;
      cnt_q       <= '0;
      dropped_q   <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      pend_q      <= 1'b0;
      first_q     <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dropped_q   <= dropped_d;
      i_q         <= i_d;
      j_q         <= j_d;
      pend_q      <= pend_d;
      first_q     <= first_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tag_q      <= tag_d;
    min_word_q <= min_word_d;
    min_idx_q  <= min_idx_d;
    word_i_q   <= word_i_d;
    wait_q     <= wait_d;
    turn_q     <= turn_d;
    wsum_q     <= wsum_d;
    tsum_q     <= tsum_d;
    cur_word_q <= cur_word_d;
    avgw_q     <= avgw_d;
    avgt_q     <= avgt_d;
    o_id_q     <= o_id_d;
    o_burst_q  <= o_burst_d;
    o_wait_q   <= o_wait_d;
    o_turn_q   <= o_turn_d;
    o_avgw_q   <= o_avgw_d;
    o_avgt_q   <= o_avgt_d;
    o_ovf_q    <= o_ovf_d;
    o_eos_q    <= o_eos_d;
  end

  // ports
  assign s_axis_tready = (state_q == sjf_pkg::ST_LOAD);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, o_avgt_q, o_avgw_q, o_turn_q, o_wait_q, o_burst_q, o_id_q};
  assign m_axis_tuser  = o_ovf_q;
  assign m_axis_tlast  = o_eos_q;

  // checks
  a_out_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == sjf_pkg::ST_OUT))
    else $error("output valid outside output state");

  a_no_load_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !out_valid_q)
    else $error("input ready while a result is pending");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_JOBS))
    else $error("job count beyond capacity");

  a_min_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sjf_pkg::ST_SWAP_A) |->
      ((CntW'(min_idx_q) >= i_q) && (CntW'(min_idx_q) < cnt_q)))
    else $error("minimum index outside the unsorted range");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
      ((cnt_q == '0) && !dropped_q && (state_q == sjf_pkg::ST_LOAD)))
    else $error("set not cleared after end of schedule");

endmodule

`default_nettype wire

// ===== rtl/sjf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sjf_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module sjf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sjf_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sjf_div - iterative restoring divider
// One quotient bit per cycle, one per dividend bit; operands latched
// on start, done pulses for one cycle with the quotient valid.
// ---------------------------------------------------------------------------
module sjf_div #(
  parameter int DvdW = 34,
  parameter int DivW = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DvdW-1:0]   dividend_i,
  input  wire logic [DivW-1:0]   divisor_i,
  output logic      [DvdW-1:0]   quotient_o,
  output sjf_pkg::div_stat_t     stat_o
);

  localparam int StepW = $clog2(DvdW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [DivW-1:0]  rem_q, rem_d;
  logic [DvdW-1:0]  quo_q, quo_d;
  logic [DivW-1:0]  dvs_q, dvs_d;
  logic [DivW:0]    shifted;
  logic [DivW:0]    diff;

  // one restoring step per cycle
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    shifted = {rem_q, quo_q[DvdW-1]};
    diff    = shifted - {1'b0, dvs_q};
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits DivW bits
      if (!diff[DivW]) begin
        rem_d = diff[DivW-1:0];
        quo_d = {quo_q[DvdW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DivW-1:0];
        quo_d = {quo_q[DvdW-2:0], 1'b0};
      end
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(DvdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - self-checking bench for sjf_schedule_calculator
// Streams sets of burst times into the scheduler and checks every result
// word against a bench-side shortest-job-first calculation. A short table of
// hand-picked sets comes first, then random sets with changing back-pressure.
// ---------------------------------------------------------------------------
module tb;

  import sjf_pkg::*;

  localparam int      MAX_JOBS     = 16;
  localparam int      RANDOM_JOBS  = 200;
  localparam int      HOLD_CYCLES  = 600;
  localparam int      DRAIN_CYCLES = 200;
  localparam realtime RUN_LIMIT    = 5ms;

  // one schedule entry as carried on the result stream
  typedef struct packed {
    logic [JOB_ID_W-1:0] job_id;
    logic [BURST_W-1:0]  burst;
    logic [WAIT_W-1:0]   waiting;
    logic [WAIT_W-1:0]   turnaround;
    logic [AVG_W-1:0]    avg_waiting;
    logic [AVG_W-1:0]    avg_turnaround;
    logic                overflow;
    logic                end_of_sched;
  } sched_entry_t;

  // directed stimulus row; typed entries are only given for one-job sets
  typedef struct {
    logic [BURST_W-1:0] burst;
    logic               last;
    bit                 typed;
    sched_entry_t       entry;
  } job_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tlast;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;

  sjf_schedule_calculator #(
    .MAX_JOBS (MAX_JOBS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  // bench copy of the job store
  logic [BURST_W-1:0]  held_burst [MAX_JOBS];
  logic [JOB_ID_W-1:0] held_id    [MAX_JOBS];
  int unsigned         held_count;
  bit                  held_dropped;

  sched_entry_t schedule_q [$];
  job_row_t     job_rows   [$];
  int unsigned  error_count;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  int unsigned  holds_asked;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("FAIL sjf_schedule_calculator");
    $finish;
  end

  // Store one accepted job; on the closing word, sort and queue the schedule.
  function automatic void schedule_job(input logic [BURST_W-1:0] burst, input logic last);
    int unsigned        pick;
    logic [BURST_W-1:0] tb_burst;
    logic [JOB_ID_W-1:0] tb_id;
    logic [63:0]        wait_acc;
    logic [63:0]        turn;
    logic [63:0]        wait_sum;
    logic [63:0]        turn_sum;
    sched_entry_t       e;

    if (held_count < MAX_JOBS) begin
      held_burst[held_count] = burst;
      held_id[held_count]    = JOB_ID_W'(held_count + 1);
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!last) return;

    // selection sort, strict less-than, always swap
    for (int i = 0; i < held_count; i++) begin
      pick = i;
      for (int j = i + 1; j < held_count; j++)
        if (held_burst[j] < held_burst[pick]) pick = j;
      tb_burst         = held_burst[i];
      held_burst[i]    = held_burst[pick];
      held_burst[pick] = tb_burst;
      tb_id            = held_id[i];
      held_id[i]       = held_id[pick];
      held_id[pick]    = tb_id;
    end

    wait_acc = '0;
    wait_sum = '0;
    turn_sum = '0;
    for (int k = 0; k < held_count; k++) begin
      turn            = wait_acc + held_burst[k];
      wait_sum        += wait_acc;
      turn_sum        += turn;
      e.job_id         = held_id[k];
      e.burst          = held_burst[k];
      e.waiting        = WAIT_W'(wait_acc);
      e.turnaround     = WAIT_W'(turn);
      e.avg_waiting    = '0;
      e.avg_turnaround = '0;
      e.overflow       = held_dropped;
      e.end_of_sched   = 1'b0;
      if (k == held_count - 1) begin
        e.avg_waiting    = AVG_W'((wait_sum << FRAC_W) / held_count);
        e.avg_turnaround = AVG_W'((turn_sum << FRAC_W) / held_count);
        e.end_of_sched   = 1'b1;
      end
      schedule_q.push_back(e);
      wait_acc = turn;
    end
    held_count   = 0;
    held_dropped = 1'b0;
  endfunction

  // Offer one job word, with random idle cycles ahead of it.
  task automatic send_job(input logic [BURST_W-1:0] burst, input logic last);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= burst;
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    schedule_job(burst, last);
  endtask

  function automatic void add_row(input logic [BURST_W-1:0] burst, input logic last,
                                  input bit typed, input sched_entry_t entry);
    job_row_t r;
    r.burst = burst;
    r.last  = last;
    r.typed = typed;
    r.entry = entry;
    job_rows.push_back(r);
  endfunction

  // Random burst: extremes and small values (many ties) mixed with full range.
  function automatic logic [BURST_W-1:0] pick_burst();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0:       return '0;
      1:       return '1;
      2, 3, 4: return BURST_W'($urandom_range(0, 15));
      default: return BURST_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Result side: ready with random gaps, plus long holds on request
  initial begin
    int unsigned hold_left;
    int unsigned holds_done;
    hold_left     = 0;
    holds_done    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    sched_entry_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (schedule_q.size() == 0) begin
        $error("result word with nothing expected: tdata %h", m_axis_tdata);
        error_count++;
      end else begin
        e = schedule_q.pop_front();
        check_field("job_id",            e.job_id,         m_axis_tdata[6:0]);
        check_field("job_burst",         e.burst,          m_axis_tdata[22:7]);
        check_field("waiting_time",      e.waiting,        m_axis_tdata[44:23]);
        check_field("turnaround_time",   e.turnaround,     m_axis_tdata[66:45]);
        check_field("avg_waiting_q8",    e.avg_waiting,    m_axis_tdata[96:67]);
        check_field("avg_turnaround_q8", e.avg_turnaround, m_axis_tdata[126:97]);
        check_field("overflow",          e.overflow,       m_axis_tuser);
        check_field("end_of_schedule",   e.end_of_sched,   m_axis_tlast);
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned  random_sent;
    int unsigned  set_len;
    sched_entry_t none;
    sched_entry_t typed_e;

    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tvalid = 1'b0;
    held_count    = 0;
    held_dropped  = 1'b0;
    error_count   = 0;
    holds_asked   = 0;
    send_idle_pct = 12;
    recv_idle_pct = 65;
    none          = '0;

    // single zero-length job
    typed_e = '{job_id: 1, burst: 0, waiting: 0, turnaround: 0, avg_waiting: 0,
                avg_turnaround: 0, overflow: 0, end_of_sched: 1};
    add_row(16'h0000, 1'b1, 1'b1, typed_e);
    // single longest job
    typed_e = '{job_id: 1, burst: 16'hFFFF, waiting: 0, turnaround: 16'hFFFF,
                avg_waiting: 0, avg_turnaround: 30'(16'hFFFF) << FRAC_W, overflow: 0,
                end_of_sched: 1};
    add_row(16'hFFFF, 1'b1, 1'b1, typed_e);
    // ties: the swaps reorder the two jobs of burst 7
    add_row(16'd7, 1'b0, 1'b0, none);
    add_row(16'd3, 1'b0, 1'b0, none);
    add_row(16'd7, 1'b0, 1'b0, none);
    add_row(16'd3, 1'b1, 1'b0, none);
    // full store of long jobs, then two dropped, the flagged last among them
    for (int k = 0; k < MAX_JOBS; k++)
      add_row(BURST_W'((k % 2) ? 16'hFFFF : 16'hFFFF - k), 1'b0, 1'b0, none);
    add_row(16'h5A5A, 1'b0, 1'b0, none);
    add_row(16'hA5A5, 1'b1, 1'b0, none);
    // overflow flag cleared for the following set
    typed_e = '{job_id: 1, burst: 1, waiting: 0, turnaround: 1, avg_waiting: 0,
                avg_turnaround: 30'd1 << FRAC_W, overflow: 0, end_of_sched: 1};
    add_row(16'h0001, 1'b1, 1'b1, typed_e);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (job_rows[r]) begin
      send_job(job_rows[r].burst, job_rows[r].last);
      // one-job set: the hand-typed entry stands in for the computed one
      if (job_rows[r].typed) begin
        void'(schedule_q.pop_back());
        schedule_q.push_back(job_rows[r].entry);
      end
    end

    // long output hold while the next sets keep coming
    holds_asked++;
    random_sent = 0;
    while (random_sent < RANDOM_JOBS) begin
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4)
                                            : $urandom_range(1, MAX_JOBS);
      for (int k = 0; k < set_len; k++) begin
        if (random_sent < RANDOM_JOBS / 3) begin
          send_idle_pct = 12;
          recv_idle_pct = 65;
        end else if (random_sent < 2 * RANDOM_JOBS / 3) begin
          send_idle_pct = 65;
          recv_idle_pct = 12;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        send_job(pick_burst(), k == set_len - 1);
        random_sent++;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (schedule_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS sjf_schedule_calculator");
    end else begin
      $display("FAIL sjf_schedule_calculator");
    end
    $finish;
  end

endmodule
